[hdl/pev_pkg.sv]
`default_nettype none

package pev_pkg;

	localparam int FRAC_BITS = 16;

	localparam int POS_W  = 32;
	localparam int VEL_W  = 24;
	localparam int FRC_W  = 32;
	localparam int MASS_W = 32;
	localparam int TS_W   = 17;
	localparam int SIZE_W = 15;

	// 50 * time_step
	localparam int GRAV  = 50;
	localparam int ACC_W = 23;

	localparam int Q_W    = FRC_W + TS_W;
	localparam int SDV_W  = Q_W + 1;
	localparam int SUM_W  = Q_W + 3;
	localparam int VP_W   = VEL_W + TS_W + 1;
	localparam int P1_W   = POS_W + 2;
	localparam int P2_W   = POS_W + 3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = TS_W;

	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WORLD_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WORLD_HEIGHT = 2'd2;

	localparam logic [TS_W-1:0]   TS_RESET     = 17'd1092;
	localparam logic [SIZE_W-1:0] WIDTH_RESET  = 15'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 15'd480;

	localparam logic signed [VEL_W-1:0] VEL_MAX  = VEL_W'(100 << FRAC_BITS);
	localparam logic signed [SUM_W-1:0] VMAX_SUM = SUM_W'(100 << FRAC_BITS);
	localparam logic signed [SUM_W-1:0] VMIN_SUM = -VMAX_SUM;
	localparam logic signed [FRC_W-1:0] DRAG     = FRC_W'(50 << FRAC_BITS);

	localparam logic signed [P2_W-1:0] POS_MAX = P2_W'(64'sd2147483647);
	localparam logic signed [P2_W-1:0] POS_MIN = -POS_MAX - P2_W'(1);

	typedef struct packed {
		logic                      active;
		logic signed [POS_W-1:0]   pos_x;
		logic signed [POS_W-1:0]   pos_y;
		logic signed [VEL_W-1:0]   vel_x;
		logic signed [VEL_W-1:0]   vel_y;
		logic signed [FRC_W-1:0]   force_x;
		logic signed [FRC_W-1:0]   force_y;
		logic        [MASS_W-1:0]  mass;
	} req_t;

	typedef struct packed {
		logic signed [POS_W-1:0] new_pos_x;
		logic signed [POS_W-1:0] new_pos_y;
		logic signed [VEL_W-1:0] new_vel_x;
		logic signed [VEL_W-1:0] new_vel_y;
		logic signed [FRC_W-1:0] new_force_x;
		logic signed [FRC_W-1:0] new_force_y;
	} res_t;

	// one axis of a request, carried alongside the lane arithmetic
	typedef struct packed {
		logic                    active;
		logic signed [POS_W-1:0] pos;
		logic signed [VEL_W-1:0] vel;
		logic signed [FRC_W-1:0] frc;
	} side_t;

	typedef struct packed {
		logic signed [POS_W-1:0] pos;
		logic signed [VEL_W-1:0] vel;
		logic signed [FRC_W-1:0] frc;
	} lane_res_t;

endpackage

`default_nettype wire

[hdl/particle_euler_step_with_wrap_top.sv]
// One semi-implicit Euler step per particle; signed Q16.16, velocity Q8.16.
// req (valid/ready): one particle; res (valid/ready): its updated state.
// cfg (valid/ready, index + data): time_step, world_width, world_height.
// cfg_ready is always high; write registers only while no request is in flight.
// Two lanes, one per axis, each with a 49-stage pipelined divider for
// force*dt/mass; an output register with a one-entry skid joins the lanes.
// Throughput: one request per cycle while res_ready is high.
// When res_ready is low the output holds, the skid takes one more result,
// then req_ready drops and the whole pipeline freezes until res is taken.
// Reset: clears the pipeline and output, loads time_step 1092,
// world_width 640, world_height 480.
`default_nettype none

module particle_euler_step_with_wrap_top (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_ready,
	input  wire pev_pkg::req_t                     req,
	output logic                                   res_valid,
	input  wire logic                              res_ready,
	output pev_pkg::res_t                          res,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [pev_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pev_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [pev_pkg::TS_W-1:0]   ts_q;
	logic [pev_pkg::SIZE_W-1:0] width_q;
	logic [pev_pkg::SIZE_W-1:0] height_q;
	logic [pev_pkg::ACC_W-1:0]  grav_q;

	logic                 pipe_en;
	pev_pkg::side_t       side_x;
	pev_pkg::side_t       side_y;
	logic                 vx;
	logic                 vy;
	pev_pkg::lane_res_t   lane_x;
	pev_pkg::lane_res_t   lane_y;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q     <= pev_pkg::TS_RESET;
			width_q  <= pev_pkg::WIDTH_RESET;
			height_q <= pev_pkg::HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				pev_pkg::REG_TIME_STEP:    ts_q     <= cfg_data;
				pev_pkg::REG_WORLD_WIDTH:  width_q  <= cfg_data[pev_pkg::SIZE_W-1:0];
				pev_pkg::REG_WORLD_HEIGHT: height_q <= cfg_data[pev_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// gravity * dt on y
	always_ff @(posedge clk) begin
		grav_q <= pev_pkg::ACC_W'(ts_q) * pev_pkg::ACC_W'(pev_pkg::GRAV);
	end

	assign req_ready = pipe_en;

	always_comb begin
		side_x.active = req.active;
		side_x.pos    = req.pos_x;
		side_x.vel    = req.vel_x;
		side_x.frc    = req.force_x;
		side_y.active = req.active;
		side_y.pos    = req.pos_y;
		side_y.vel    = req.vel_y;
		side_y.frc    = req.force_y;
	end

	pev_lane u_lane_x (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.valid     (req_valid),
		.side      (side_x),
		.mass      (req.mass),
		.time_step (ts_q),
		.accel     ('0),
		.size      (width_q),
		.res_valid (vx),
		.res       (lane_x)
	);

	pev_lane u_lane_y (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (pipe_en),
		.valid     (req_valid),
		.side      (side_y),
		.mass      (req.mass),
		.time_step (ts_q),
		.accel     (grav_q),
		.size      (height_q),
		.res_valid (vy),
		.res       (lane_y)
	);

	pev_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (vx),
		.lane_x    (lane_x),
		.lane_y    (lane_y),
		.pipe_en   (pipe_en),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		vx == vy)
		else $error("axis lanes out of step");

endmodule

`default_nettype wire

[hdl/pev_div.sv]
`default_nettype none

module pev_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         valid,
	input  wire logic [pev_pkg::Q_W-1:0]      num,
	input  wire logic [pev_pkg::MASS_W-1:0]   den,
	input  wire pev_pkg::side_t               side,
	output logic                              quo_valid,
	output logic [pev_pkg::Q_W-1:0]           quo,
	output pev_pkg::side_t                    quo_side
);

	localparam int QW = pev_pkg::Q_W;
	localparam int DW = pev_pkg::MASS_W;

	logic                 vld_s  [QW];
	logic [DW-1:0]        rem_s  [QW];
	logic [QW-1:0]        nq_s   [QW];
	logic [DW-1:0]        den_s  [QW];
	pev_pkg::side_t       side_s [QW];

	// restoring division, one quotient bit per stage
	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic           v_in;
		logic [DW-1:0]  rem_in;
		logic [QW-1:0]  nq_in;
		logic [DW-1:0]  den_in;
		pev_pkg::side_t side_in;
		logic [DW:0]    trial;
		logic           ge;

		if (k == 0) begin : g_first
			assign v_in    = valid;
			assign rem_in  = '0;
			assign nq_in   = num;
			assign den_in  = den;
			assign side_in = side;
		end else begin : g_next
			assign v_in    = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign nq_in   = nq_s[k-1];
			assign den_in  = den_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign trial = {rem_in, nq_in[QW-1]};
		assign ge    = trial >= {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
				nq_s[k]   <= {nq_in[QW-2:0], ge};
				den_s[k]  <= den_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign quo_valid = vld_s[QW-1];
	assign quo       = nq_s[QW-1];
	assign quo_side  = side_s[QW-1];

	a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[QW-1] |-> rem_s[QW-1] < den_s[QW-1])
		else $error("divider remainder not below divisor");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[0] |-> den_s[0] != '0)
		else $error("divider saw zero divisor");

endmodule

`default_nettype wire

[hdl/pev_lane.sv]
`default_nettype none

module pev_lane (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         valid,
	input  wire pev_pkg::side_t               side,
	input  wire logic [pev_pkg::MASS_W-1:0]   mass,
	input  wire logic [pev_pkg::TS_W-1:0]     time_step,
	input  wire logic [pev_pkg::ACC_W-1:0]    accel,
	input  wire logic [pev_pkg::SIZE_W-1:0]   size,
	output logic                              res_valid,
	output pev_pkg::lane_res_t                res
);

	localparam int FB = pev_pkg::FRAC_BITS;

	// s1: magnitude of force, divisor
	logic                            v_s1;
	pev_pkg::side_t                  side_s1;
	logic [pev_pkg::FRC_W-1:0]       mag_s1;
	logic [pev_pkg::MASS_W-1:0]      den_s1;

	// s2: |force| * dt
	logic                            v_s2;
	pev_pkg::side_t                  side_s2;
	logic [pev_pkg::Q_W-1:0]         prod_s2;
	logic [pev_pkg::MASS_W-1:0]      den_s2;

	logic                            qv;
	logic [pev_pkg::Q_W-1:0]         quo;
	pev_pkg::side_t                  qside;

	logic                            v_s3;
	pev_pkg::side_t                  side_s3;
	logic signed [pev_pkg::SDV_W-1:0] sdv_s3;

	logic signed [pev_pkg::SUM_W-1:0] vsum;
	logic                            v_s4;
	pev_pkg::side_t                  side_s4;
	logic signed [pev_pkg::VEL_W-1:0] vel_s4;

	logic                            v_s5;
	pev_pkg::side_t                  side_s5;
	logic signed [pev_pkg::VEL_W-1:0] vel_s5;
	logic signed [pev_pkg::VP_W-1:0]  vp_s5;

	logic                            v_s6;
	pev_pkg::side_t                  side_s6;
	logic signed [pev_pkg::VEL_W-1:0] vel_s6;
	logic signed [pev_pkg::P1_W-1:0]  p1_s6;

	logic signed [pev_pkg::P2_W-1:0]  lim;
	logic signed [pev_pkg::P2_W-1:0]  p1x;
	logic                            v_s7;
	pev_pkg::side_t                  side_s7;
	logic signed [pev_pkg::VEL_W-1:0] vel_s7;
	logic signed [pev_pkg::P2_W-1:0]  p2_s7;

	logic signed [pev_pkg::POS_W-1:0] pos_sat;
	logic signed [pev_pkg::FRC_W-1:0] frc_res;
	logic                            v_s8;
	pev_pkg::lane_res_t              res_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid;
			v_s2 <= v_s1;
			v_s3 <= qv;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side;
			mag_s1  <= side.frc[pev_pkg::FRC_W-1] ? (~side.frc + 1'b1) : side.frc;
			den_s1  <= (mass == '0) ? pev_pkg::MASS_W'(1) : mass;

			side_s2 <= side_s1;
			prod_s2 <= pev_pkg::Q_W'(mag_s1) * pev_pkg::Q_W'(time_step);
			den_s2  <= den_s1;
		end
	end

	pev_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.valid     (v_s2),
		.num       (prod_s2),
		.den       (den_s2),
		.side      (side_s2),
		.quo_valid (qv),
		.quo       (quo),
		.quo_side  (qside)
	);

	assign vsum = $signed({{(pev_pkg::SUM_W-pev_pkg::VEL_W){side_s3.vel[pev_pkg::VEL_W-1]}},
			side_s3.vel})
		+ $signed({{(pev_pkg::SUM_W-pev_pkg::SDV_W){sdv_s3[pev_pkg::SDV_W-1]}}, sdv_s3})
		+ $signed({{(pev_pkg::SUM_W-pev_pkg::ACC_W){1'b0}}, accel});

	assign lim = $signed({{(pev_pkg::P2_W-pev_pkg::SIZE_W-FB){1'b0}}, size, {FB{1'b0}}});
	assign p1x = $signed({p1_s6[pev_pkg::P1_W-1], p1_s6});

	always_comb begin
		if (p2_s7 > pev_pkg::POS_MAX) begin
			pos_sat = pev_pkg::POS_MAX[pev_pkg::POS_W-1:0];
		end else if (p2_s7 < pev_pkg::POS_MIN) begin
			pos_sat = pev_pkg::POS_MIN[pev_pkg::POS_W-1:0];
		end else begin
			pos_sat = p2_s7[pev_pkg::POS_W-1:0];
		end

		if (side_s7.frc > pev_pkg::DRAG) begin
			frc_res = side_s7.frc - pev_pkg::DRAG;
		end else if (side_s7.frc < -pev_pkg::DRAG) begin
			frc_res = side_s7.frc + pev_pkg::DRAG;
		end else begin
			frc_res = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= qside;
			sdv_s3  <= qside.frc[pev_pkg::FRC_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

			side_s4 <= side_s3;
			if (vsum > pev_pkg::VMAX_SUM) begin
				vel_s4 <= pev_pkg::VEL_MAX;
			end else if (vsum < pev_pkg::VMIN_SUM) begin
				vel_s4 <= -pev_pkg::VEL_MAX;
			end else begin
				vel_s4 <= vsum[pev_pkg::VEL_W-1:0];
			end

			side_s5 <= side_s4;
			vel_s5  <= vel_s4;
			vp_s5   <= pev_pkg::VP_W'(vel_s4) * pev_pkg::VP_W'($signed({1'b0, time_step}));

			side_s6 <= side_s5;
			vel_s6  <= vel_s5;
			// arithmetic shift: floor of velocity * dt
			p1_s6   <= pev_pkg::P1_W'(side_s5.pos) + pev_pkg::P1_W'(vp_s5 >>> FB);

			side_s7 <= side_s6;
			vel_s7  <= vel_s6;
			if (p1x > lim) begin
				p2_s7 <= p1x - lim;
			end else if (p1x < 0) begin
				p2_s7 <= p1x + lim;
			end else begin
				p2_s7 <= p1x;
			end

			res_s8.pos <= side_s7.active ? pos_sat : side_s7.pos;
			res_s8.vel <= side_s7.active ? vel_s7 : side_s7.vel;
			res_s8.frc <= side_s7.active ? frc_res : side_s7.frc;
		end
	end

	assign res_valid = v_s8;
	assign res       = res_s8;

	a_vel_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (vel_s4 <= pev_pkg::VEL_MAX && vel_s4 >= -pev_pkg::VEL_MAX))
		else $error("velocity outside clamp range");

endmodule

`default_nettype wire

[hdl/pev_merge.sv]
`default_nettype none

module pev_merge (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 valid,
	input  wire pev_pkg::lane_res_t   lane_x,
	input  wire pev_pkg::lane_res_t   lane_y,
	output logic                      pipe_en,
	output logic                      res_valid,
	input  wire logic                 res_ready,
	output pev_pkg::res_t             res
);

	pev_pkg::res_t merged;
	pev_pkg::res_t out_q;
	pev_pkg::res_t skid_q;
	logic          out_v_q;
	logic          skid_v_q;

	always_comb begin
		merged.new_pos_x   = lane_x.pos;
		merged.new_pos_y   = lane_y.pos;
		merged.new_vel_x   = lane_x.vel;
		merged.new_vel_y   = lane_y.vel;
		merged.new_force_x = lane_x.frc;
		merged.new_force_y = lane_y.frc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || res_ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= valid;
			end
		end else if (valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || res_ready) begin
			out_q <= skid_v_q ? skid_q : merged;
		end
		if (out_v_q && !res_ready && !skid_v_q) begin
			skid_q <= merged;
		end
	end

	assign pipe_en   = !skid_v_q;
	assign res_valid = out_v_q;
	assign res       = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid holds a result while output is empty");

endmodule

`default_nettype wire
